FILE: design/mbsc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbsc_pkg: shared types and constants
// reset values of the key registers, register indexes and the request and
// response structs between the exponent sequencer and the serial multiplier
// ---------------------------------------------------------------------------
package mbsc_pkg;

	localparam int unsigned WordW = 16;
	localparam int unsigned ByteW = 8;
	localparam int unsigned CntW  = 4;

	localparam logic [WordW-1:0] ModulusReset  = 16'd3233;
	localparam logic [WordW-1:0] ExponentReset = 16'd17;

	// register indexes on the write port
	localparam logic [1:0] RegModulus  = 2'd0;
	localparam logic [1:0] RegExponent = 2'd1;
	localparam logic [1:0] RegDecrypt  = 2'd2;

	// one operation for the serial modular multiplier: a * b mod n
	typedef struct packed {
		logic             start;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
	} mm_req_t;

	// finished value, done is a one-cycle pulse
	typedef struct packed {
		logic             done;
		logic [WordW-1:0] res;
	} mod_rsp_t;

endpackage

FILE: design/mbsc_modmul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbsc_modmul: bit-serial modular multiplier
// interleaved shift-add with reduction, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module mbsc_modmul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbsc_pkg::mm_req_t             req,
	input  logic [mbsc_pkg::WordW-1:0]    modulus,
	output mbsc_pkg::mod_rsp_t            rsp
);

	logic                          run_q;
	logic                          done_q;
	logic [mbsc_pkg::CntW-1:0]     cnt_q;
	logic [mbsc_pkg::WordW-1:0]    a_q;
	logic [mbsc_pkg::WordW-1:0]    b_q;
	logic [mbsc_pkg::WordW-1:0]    r_q;
	logic [mbsc_pkg::WordW+1:0]    sum;
	logic [mbsc_pkg::WordW+1:0]    red1;
	logic [mbsc_pkg::WordW+1:0]    red2;
	logic [mbsc_pkg::WordW+1:0]    n_ext;

	// r < n and a <= n, so 2r + a < 3n: two conditional subtracts
	always_comb begin
		n_ext = {2'b00, modulus};
		sum   = {1'b0, r_q, 1'b0} + (b_q[mbsc_pkg::WordW-1] ? {2'b00, a_q} : '0);
		red1  = (sum >= n_ext) ? sum - n_ext : sum;
		red2  = (red1 >= n_ext) ? red1 - n_ext : red1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			r_q <= '0;
		end else if (run_q) begin
			b_q <= {b_q[mbsc_pkg::WordW-2:0], 1'b0};
			r_q <= red2[mbsc_pkg::WordW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = r_q;

endmodule

FILE: design/mbsc_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbsc_engine: square-and-multiply sequencer
// walks the exponent lsb first through a shift register, sharing one
// serial modular multiplier for reduction, multiplies and squarings
// ---------------------------------------------------------------------------
module mbsc_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mbsc_pkg::WordW-1:0]    value,
	input  logic [mbsc_pkg::WordW-1:0]    modulus,
	input  logic [mbsc_pkg::WordW-1:0]    exponent,
	output mbsc_pkg::mod_rsp_t            rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_STEP,
		S_MUL,
		S_SQR
	} state_t;

	state_t                        state_q;
	mbsc_pkg::mm_req_t             req_q;
	mbsc_pkg::mod_rsp_t            mm_rsp;
	logic                          done_q;
	logic [mbsc_pkg::WordW-1:0]    res_q;
	logic [mbsc_pkg::WordW-1:0]    acc_q;
	logic [mbsc_pkg::WordW-1:0]    base_q;
	logic [mbsc_pkg::WordW-1:0]    exp_q;

	mbsc_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_q),
		.modulus (modulus),
		.rsp     (mm_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q.start <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			done_q      <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (modulus == '0 || exponent == mbsc_pkg::WordW'(1)) begin
							// no reduction: value passes through as it is
							res_q  <= value;
							done_q <= 1'b1;
						end else begin
							req_q.start <= 1'b1;
							req_q.a     <= mbsc_pkg::WordW'(1);
							req_q.b     <= value;
							acc_q       <= (modulus == mbsc_pkg::WordW'(1)) ?
							               '0 : mbsc_pkg::WordW'(1);
							exp_q       <= exponent;
							state_q     <= S_RED;
						end
					end
				end
				S_RED: begin
					if (mm_rsp.done) begin
						base_q  <= mm_rsp.res;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (exp_q == '0) begin
						res_q   <= acc_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (exp_q[0]) begin
						req_q.start <= 1'b1;
						req_q.a     <= acc_q;
						req_q.b     <= base_q;
						state_q     <= S_MUL;
					end else begin
						req_q.start <= 1'b1;
						req_q.a     <= base_q;
						req_q.b     <= base_q;
						state_q     <= S_SQR;
					end
				end
				S_MUL: begin
					if (mm_rsp.done) begin
						acc_q <= mm_rsp.res;
						if (exp_q[mbsc_pkg::WordW-1:1] == '0) begin
							// top bit done, skip the last squaring
							exp_q   <= '0;
							state_q <= S_STEP;
						end else begin
							req_q.start <= 1'b1;
							req_q.a     <= base_q;
							req_q.b     <= base_q;
							state_q     <= S_SQR;
						end
					end
				end
				S_SQR: begin
					if (mm_rsp.done) begin
						base_q  <= mm_rsp.res;
						exp_q   <= {1'b0, exp_q[mbsc_pkg::WordW-1:1]};
						state_q <= S_STEP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

FILE: design/modexp_byte_stream_cipher_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modexp_byte_stream_cipher_top: byte stream cipher, value^exponent mod n
// encrypt: one byte in, low then high byte of the 16-bit result out
// decrypt: two bytes in (low, high), low byte of the result out
// ---------------------------------------------------------------------------
// throughput: one value at a time on the single shared bit-serial multiplier;
//   the first byte of a decrypt pair is only held and starts no job
// reset: arst_n clears control state, keys to modulus 3233, exponent 17, encrypt
// ---------------------------------------------------------------------------
module modexp_byte_stream_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // last
	// key register write port
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data
);

	// key and mode registers
	logic [mbsc_pkg::WordW-1:0]    modulus_q;
	logic [mbsc_pkg::WordW-1:0]    exponent_q;
	logic                          decrypt_q;

	// decrypt pairing
	logic [mbsc_pkg::ByteW-1:0]    held_q;
	logic                          have_q;

	// job tracking and result buffer
	logic                          job_busy_q;
	logic                          job_two_q;
	logic                          res_valid_q;
	logic [mbsc_pkg::WordW-1:0]    res_q;

	// output register, with the high byte of an encrypt result queued behind
	logic                          m_tvalid_q;
	logic [mbsc_pkg::ByteW-1:0]    m_tdata_q;
	logic                          m_tlast_q;
	logic                          hi_pend_q;
	logic [mbsc_pkg::ByteW-1:0]    hi_q;

	logic                          in_beat;
	logic                          eng_start;
	logic [mbsc_pkg::WordW-1:0]    eng_value;
	logic                          out_free;
	mbsc_pkg::mod_rsp_t            eng_rsp;

	// one value in flight; a finished result may still sit in the output stage
	assign s_tready  = !job_busy_q;
	assign in_beat   = s_tvalid && s_tready;

	// encrypt starts on every byte, decrypt on the second byte of a pair
	assign eng_start = in_beat && (!decrypt_q || have_q);
	assign eng_value = decrypt_q ? {s_tdata, held_q} : {{mbsc_pkg::ByteW{1'b0}}, s_tdata};

	// output stage can take a new result when empty or draining its last beat
	assign out_free  = !m_tvalid_q || (m_tready && !hi_pend_q);

	mbsc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (eng_start),
		.value    (eng_value),
		.modulus  (modulus_q),
		.exponent (exponent_q),
		.rsp      (eng_rsp)
	);

	// key registers; a mode write drops any held low byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= mbsc_pkg::ModulusReset;
			exponent_q <= mbsc_pkg::ExponentReset;
			decrypt_q  <= 1'b0;
			held_q     <= '0;
			have_q     <= 1'b0;
		end else begin
			if (in_beat && decrypt_q) begin
				if (have_q) begin
					held_q <= '0;
					have_q <= 1'b0;
				end else begin
					held_q <= s_tdata;
					have_q <= 1'b1;
				end
			end
			if (wr_en) begin
				case (wr_index)
					mbsc_pkg::RegModulus:  modulus_q  <= wr_data;
					mbsc_pkg::RegExponent: exponent_q <= wr_data;
					mbsc_pkg::RegDecrypt: begin
						decrypt_q <= wr_data[0];
						held_q    <= '0;
						have_q    <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// job control, result buffer and output beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_busy_q  <= 1'b0;
			job_two_q   <= 1'b0;
			res_valid_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			hi_pend_q   <= 1'b0;
		end else begin
			if (eng_start) begin
				job_busy_q <= 1'b1;
				job_two_q  <= !decrypt_q;
			end

			if (eng_rsp.done) begin
				res_valid_q <= 1'b1;
			end

			// beat taken downstream: move on to the queued high byte or go empty
			if (m_tvalid_q && m_tready) begin
				if (hi_pend_q) begin
					m_tlast_q <= 1'b1;
					hi_pend_q <= 1'b0;
				end else begin
					m_tvalid_q <= 1'b0;
				end
			end

			// hand the buffered result to the output stage
			if (res_valid_q && out_free) begin
				m_tvalid_q  <= 1'b1;
				m_tlast_q   <= !job_two_q;
				hi_pend_q   <= job_two_q;
				res_valid_q <= 1'b0;
				job_busy_q  <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (eng_rsp.done) begin
			res_q <= eng_rsp.res;
		end
		if (m_tvalid_q && m_tready && hi_pend_q) begin
			m_tdata_q <= hi_q;
		end
		if (res_valid_q && out_free) begin
			m_tdata_q <= res_q[mbsc_pkg::ByteW-1:0];
			hi_q      <= res_q[mbsc_pkg::WordW-1:mbsc_pkg::ByteW];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: design/mbsc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbsc_checker: port-level checks for the byte stream cipher
// watches the stream handshakes over time, attached by bind
// ---------------------------------------------------------------------------
module mbsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// a stalled output beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// the low byte of an encrypt result is always followed by its high byte
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("high byte missing after low byte");

	// input side only closes after taking a beat
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tready))
		else $error("input ready dropped without a beat");

	// a new result only appears while a value was in flight
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared with no value in flight");

endmodule

bind modexp_byte_stream_cipher_top mbsc_checker u_mbsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: tb/modexp_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modexp_stream_checker: watches the cipher's channels and checks its output
// mirrors the key registers from the write port, predicts the bytes each
// accepted input beat must cause and compares every output beat in order
// ---------------------------------------------------------------------------
module modexp_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_beat_t;

	cipher_beat_t cipher_bytes_due[$];

	logic [15:0] key_modulus;
	logic [15:0] key_exponent;
	logic        decrypt_on;
	logic [7:0]  held_low;
	logic        have_low;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// square and multiply, with the pass-through cases of the scheme
	function automatic logic [15:0] power_mod(input logic [31:0] value);
		logic [31:0] n;
		logic [31:0] base;
		logic [31:0] acc;
		logic [15:0] e;
		n = {16'b0, key_modulus};
		e = key_exponent;
		if (n == 0 || e == 16'd1)
			return value[15:0];
		base = value % n;
		acc  = 32'd1 % n;
		while (e != 0) begin
			if (e[0])
				acc = (acc * base) % n;
			base = (base * base) % n;
			e = e >> 1;
		end
		return acc[15:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cipher_beat_t want;
		logic [15:0]  r;
		if (!arst_n) begin
			key_modulus  = mbsc_pkg::ModulusReset;
			key_exponent = mbsc_pkg::ExponentReset;
			decrypt_on   = 1'b0;
			held_low     = 8'd0;
			have_low     = 1'b0;
			cipher_bytes_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (cipher_bytes_due.size() == 0) begin
					report_mismatch("output beat with nothing due", 8'h00, m_tdata);
				end else begin
					want = cipher_bytes_due.pop_front();
					if (m_tdata !== want.data)
						report_mismatch("out_byte", want.data, m_tdata);
					if (m_tlast !== want.last)
						report_mismatch("last", {7'b0, want.last}, {7'b0, m_tlast});
				end
			end
			if (wr_en) begin
				case (wr_index)
					mbsc_pkg::RegModulus:  key_modulus = wr_data;
					mbsc_pkg::RegExponent: key_exponent = wr_data;
					mbsc_pkg::RegDecrypt: begin
						// a mode write drops any half pair
						decrypt_on = wr_data[0];
						held_low   = 8'd0;
						have_low   = 1'b0;
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (!decrypt_on) begin
					r = power_mod({24'b0, s_tdata});
					cipher_bytes_due.push_back('{data: r[7:0], last: 1'b0});
					cipher_bytes_due.push_back('{data: r[15:8], last: 1'b1});
				end else if (!have_low) begin
					held_low = s_tdata;
					have_low = 1'b1;
				end else begin
					r = power_mod({16'b0, s_tdata, held_low});
					held_low = 8'd0;
					have_low = 1'b0;
					cipher_bytes_due.push_back('{data: r[7:0], last: 1'b1});
				end
			end
		end
		pending = cipher_bytes_due.size();
	end

endmodule

FILE: tb/tb_modexp_byte_stream_cipher_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_modexp_byte_stream_cipher_top: stimulus and verdict for the cipher
// a directed pass over key extremes, pass-through and half-pair drop, then
// random key phases in both modes with bursty idling on both streams
// ---------------------------------------------------------------------------
module tb_modexp_byte_stream_cipher_top;

	// settle wait, long enough for a value still in flight in a busy block to finish
	localparam int SETTLE_CYCLES = 700;
	// above the slowest run: roughly 580 values at their longest, plus stalls and settles
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int RANDOM_BEATS  = 555;
	localparam int CALM_TAIL     = 60;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [15:0] wr_data;

	int fail_count;
	int pending;
	int cycle_count;
	bit calm;

	modexp_byte_stream_cipher_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	modexp_stream_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hang or a lost beat ends here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("modexp_byte_stream_cipher_top verification failed");
		$finish;
	end

	// receiver: stalls in bursts of random length unless calm
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// one input beat, with an optional gap in front; called and returns at a
	// falling edge, tvalid left high so back-to-back beats need no dip
	task automatic push_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// stop sending and wait for every due byte to come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// drained and quiet: a held half pair starts no job and stays held
	task automatic wait_idle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one register write per cycle, enable stays high across a sequence
	task automatic write_key(input logic [1:0] idx, input logic [15:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
	endtask

	task automatic close_writes();
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_modulus();
		case ($urandom_range(0, 5))
			0: return 16'd2;
			1: return 16'hFFFF;
			2: return mbsc_pkg::ModulusReset;
			3: return 16'($urandom_range(2, 255));
			4: return 16'($urandom_range(256, 65535));
			default: return 16'($urandom_range(2, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_exponent();
		case ($urandom_range(0, 5))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return 16'd2;
			3: return 16'($urandom_range(1, 31));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	initial begin
		int  remaining;
		int  phase;
		int  count;
		bit  wrote;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		wr_en    = 1'b0;
		wr_index = mbsc_pkg::RegModulus;
		wr_data  = 16'h0000;
		calm     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset keys, encrypt: byte extremes and alternating bit patterns
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h01);
		push_byte(8'h55);
		push_byte(8'hAA);

		// largest modulus and exponent
		wait_idle();
		write_key(mbsc_pkg::RegModulus, 16'hFFFF);
		write_key(mbsc_pkg::RegExponent, 16'hFFFF);
		close_writes();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h02);

		// exponent one passes the byte through even above the modulus
		wait_idle();
		write_key(mbsc_pkg::RegModulus, 16'd2);
		write_key(mbsc_pkg::RegExponent, 16'd1);
		close_writes();
		push_byte(8'hFF);
		push_byte(8'h80);

		// decrypt with pass-through: full 16-bit pair, low byte out
		wait_idle();
		write_key(mbsc_pkg::RegDecrypt, 16'd1);
		close_writes();
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h3C);
		push_byte(8'h00);

		// decrypt with the largest key, value equal to the modulus among them
		wait_idle();
		write_key(mbsc_pkg::RegModulus, 16'hFFFF);
		write_key(mbsc_pkg::RegExponent, 16'hFFFF);
		close_writes();
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h34);
		push_byte(8'h12);

		// half pair left held, then dropped by a mode write
		push_byte(8'h77);
		wait_idle();
		write_key(mbsc_pkg::RegDecrypt, 16'd1);
		close_writes();
		push_byte(8'h21);
		push_byte(8'h43);

		// smallest modulus, squaring, back to encrypt
		wait_idle();
		write_key(mbsc_pkg::RegModulus, 16'd2);
		write_key(mbsc_pkg::RegExponent, 16'd2);
		write_key(mbsc_pkg::RegDecrypt, 16'd0);
		close_writes();
		push_byte(8'h03);
		push_byte(8'hFE);

		// random key phases; odd decrypt phases leave a half pair behind
		remaining = RANDOM_BEATS;
		phase     = 0;
		while (remaining > 0) begin
			wait_idle();
			wrote = 1'b0;
			if (phase == 0 || $urandom_range(0, 1) == 1) begin
				write_key(mbsc_pkg::RegModulus, pick_modulus());
				wrote = 1'b1;
			end
			if (phase == 0 || $urandom_range(0, 1) == 1) begin
				write_key(mbsc_pkg::RegExponent, pick_exponent());
				wrote = 1'b1;
			end
			if (phase == 0 || $urandom_range(0, 2) == 0) begin
				write_key(mbsc_pkg::RegDecrypt, {15'b0, 1'($urandom_range(0, 1))});
				wrote = 1'b1;
			end
			if (wrote)
				close_writes();
			count = $urandom_range(16, 56);
			if (count > remaining)
				count = remaining;
			calm = (remaining <= CALM_TAIL) || ($urandom_range(0, 4) == 0);
			for (int i = 0; i < count; i++) begin
				// hold the sender until the output has fully caught up
				if (phase == 2 && i == count / 2)
					drain();
				push_byte(8'($urandom_range(0, 255)));
			end
			remaining -= count;
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("modexp_byte_stream_cipher_top verification clean");
		else
			$display("modexp_byte_stream_cipher_top verification failed");
		$finish;
	end

endmodule
